[hdl/iit_pkg.sv]
`default_nettype none
package iit_pkg;
  localparam int unsigned PIX_W = 8;
  localparam int unsigned BINS = 256;
  localparam int unsigned BIN_W = 21;
  localparam logic [BIN_W-1:0] BIN_LIMIT = {BIN_W{1'b1}};
  localparam int unsigned SUM_W = BIN_W + 8 + 8;
  localparam int unsigned CNT_W = BIN_W + 8;
  localparam int unsigned MAX_PIXELS = 1048576;
  localparam logic [7:0] ITER_RESET = 8'd100;

  typedef struct packed {
    logic clr_start;
    logic acc_start;
    logic div_start;
    logic load_mid;
    logic take_next;
    logic frame_clear;
  } ctl_cmd_t;

  typedef struct packed {
    logic sweep_done;
    logic div_done;
    logic flat;
    logic converged;
  } ctl_sts_t;
endpackage
`default_nettype wire

[hdl/iit_datapath.sv]
`default_nettype none
module iit_datapath (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            px_we,
  input  wire logic [7:0]      px,
  input  wire iit_pkg::ctl_cmd_t cmd,
  output iit_pkg::ctl_sts_t    sts,
  output logic [7:0]           thr
);
  import iit_pkg::*;

  logic [BIN_W-1:0] mem [BINS];
  logic [7:0]       gmin_r, gmin_nxt, gmax_r, gmax_nxt;
  logic [7:0]       t_r, t_nxt;
  // read-modify-write hazard pipeline for pixel accumulation
  logic             wb_v_r;
  logic [7:0]       wb_a_r;
  logic [BIN_W-1:0] wb_d_r;
  logic [BIN_W-1:0] rd_r;
  logic             rd_v_r;
  logic [7:0]       rd_a_r;
  // sweep
  logic             clr_act_r, acc_act_r;
  logic [7:0]       sw_r;
  logic             sv_r;
  logic [7:0]       sa_r;
  logic             sweep_done_r;
  logic [SUM_W-1:0] s1_r, s2_r;
  logic [CNT_W-1:0] c1_r, c2_r;
  logic [BIN_W+7:0] prod;
  // dividers
  logic [5:0]       dcnt_r;
  logic             dbusy_r, div_done_r;
  logic [7:0]       q1_r, q2_r;
  logic [CNT_W-1:0] r1_r, r2_r;
  logic [SUM_W-1:0] n1_r, n2_r;
  logic [7:0]       m1, m2;
  logic [8:0]       msum;
  logic [BIN_W-1:0] inc;
  logic [CNT_W:0]   tr1, tr2;

  always_comb begin
    inc = (rd_v_r && wb_v_r && wb_a_r == rd_a_r) ? wb_d_r : rd_r;
    if (inc != BIN_LIMIT) inc = inc + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (acc_act_r) rd_r <= mem[sw_r];
    else if (px_we) rd_r <= mem[px];
    if (clr_act_r) mem[sw_r] <= '0;
    else if (rd_v_r) mem[rd_a_r] <= inc;
    rd_a_r <= px;
    wb_a_r <= rd_a_r;
    wb_d_r <= inc;
    if (acc_act_r) sa_r <= sw_r;
  end

  always_comb begin
    gmin_nxt = gmin_r;
    gmax_nxt = gmax_r;
    if (px_we && px < gmin_r) gmin_nxt = px;
    if (px_we && px > gmax_r) gmax_nxt = px;
    if (cmd.frame_clear) begin
      gmin_nxt = 8'd255;
      gmax_nxt = 8'd0;
    end
    t_nxt = t_r;
    if (cmd.load_mid) t_nxt = 8'((9'(gmin_r) + 9'(gmax_r)) >> 1);
    else if (cmd.take_next) t_nxt = msum[8:1];
  end

  assign prod = {8'd0, rd_r} * {{BIN_W{1'b0}}, sa_r};
  assign tr1 = {r1_r, n1_r[SUM_W-1]} - {1'b0, c1_r};
  assign tr2 = {r2_r, n2_r[SUM_W-1]} - {1'b0, c2_r};
  assign m1 = (t_r == 8'd0 || c1_r == '0) ? gmin_r : q1_r;
  assign m2 = (c2_r == '0) ? gmax_r : q2_r;
  assign msum = 9'(m1) + 9'(m2);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gmin_r <= 8'd255; gmax_r <= 8'd0;
      wb_v_r <= 1'b0; rd_v_r <= 1'b0;
      clr_act_r <= 1'b0; acc_act_r <= 1'b0; sv_r <= 1'b0;
      sweep_done_r <= 1'b0; dbusy_r <= 1'b0; div_done_r <= 1'b0;
      sw_r <= '0; dcnt_r <= '0;
    end else begin
      gmin_r <= gmin_nxt; gmax_r <= gmax_nxt;
      rd_v_r <= px_we;
      wb_v_r <= rd_v_r;
      sweep_done_r <= 1'b0;
      div_done_r <= 1'b0;
      sv_r <= acc_act_r;
      if (cmd.clr_start) begin
        clr_act_r <= 1'b1; sw_r <= '0;
      end else if (cmd.acc_start) begin
        acc_act_r <= 1'b1; sw_r <= '0;
        s1_r <= '0; s2_r <= '0; c1_r <= '0; c2_r <= '0;
      end else if (clr_act_r || acc_act_r) begin
        sw_r <= sw_r + 1'b1;
        if (sw_r == 8'd255) begin
          clr_act_r <= 1'b0; acc_act_r <= 1'b0;
          if (clr_act_r) sweep_done_r <= 1'b1;
        end
      end
      if (sv_r) begin
        if (sa_r >= gmin_r && sa_r < t_r) begin
          s1_r <= s1_r + SUM_W'(prod);
          c1_r <= c1_r + CNT_W'(rd_r);
        end
        if (sa_r > t_r && sa_r <= gmax_r) begin
          s2_r <= s2_r + SUM_W'(prod);
          c2_r <= c2_r + CNT_W'(rd_r);
        end
        if (sa_r == 8'd255) sweep_done_r <= 1'b1;
      end
      if (cmd.div_start) begin
        dbusy_r <= 1'b1; dcnt_r <= '0;
        n1_r <= s1_r; n2_r <= s2_r; r1_r <= '0; r2_r <= '0;
      end else if (dbusy_r) begin
        n1_r <= {n1_r[SUM_W-2:0], ~tr1[CNT_W]};
        n2_r <= {n2_r[SUM_W-2:0], ~tr2[CNT_W]};
        r1_r <= tr1[CNT_W] ? {r1_r[CNT_W-2:0], n1_r[SUM_W-1]} : tr1[CNT_W-1:0];
        r2_r <= tr2[CNT_W] ? {r2_r[CNT_W-2:0], n2_r[SUM_W-1]} : tr2[CNT_W-1:0];
        dcnt_r <= dcnt_r + 1'b1;
        if (dcnt_r == 6'(SUM_W - 1)) begin
          dbusy_r <= 1'b0; div_done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    t_r <= t_nxt;
    if (div_done_r) begin
      q1_r <= n1_r[7:0]; q2_r <= n2_r[7:0];
    end
  end

  assign sts.sweep_done = sweep_done_r;
  assign sts.div_done   = div_done_r;
  assign sts.flat       = (gmin_r == gmax_r);
  assign sts.converged  = (msum[8:1] == t_r);
  assign thr            = t_r;

  assert property (@(posedge clk) disable iff (!rst_n) !(clr_act_r && acc_act_r))
    else $error("clear and sum sweeps overlap");
  assert property (@(posedge clk) disable iff (!rst_n) cmd.div_start |=> dbusy_r)
    else $error("divider did not start");
  assert property (@(posedge clk) disable iff (!rst_n) clr_act_r |-> !rd_v_r)
    else $error("pixel write during clear");
endmodule
`default_nettype wire

[hdl/iit_ctrl.sv]
`default_nettype none
module iit_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  input  wire logic              in_last_pixel,
  input  wire logic [7:0]        max_iter,
  input  wire iit_pkg::ctl_sts_t sts,
  output iit_pkg::ctl_cmd_t      cmd,
  output logic                   busy,
  output logic                   done
);
  import iit_pkg::*;

  typedef enum logic [7:0] {
    S_RUN   = 8'b0000_0001,
    S_WAIT  = 8'b0000_0010,
    S_SUM   = 8'b0000_0100,
    S_DIV   = 8'b0000_1000,
    S_STEP  = 8'b0001_0000,
    S_OUT   = 8'b0010_0000,
    S_CLR   = 8'b0100_0000,
    S_INIT  = 8'b1000_0000
  } state_t;

  state_t     st_r, st_nxt;
  logic [7:0] rnd_r, rnd_nxt;
  logic [7:0] lim;
  logic       w_r, w_nxt;

  assign lim = (max_iter == 8'd0) ? 8'd1 : max_iter;

  always_comb begin
    st_nxt = st_r;
    rnd_nxt = rnd_r;
    w_nxt = 1'b0;
    cmd = '0;
    done = 1'b0;
    unique case (st_r)
      S_INIT: begin
        cmd.clr_start = 1'b1; st_nxt = S_CLR;
      end
      S_RUN: if (start && in_last_pixel) st_nxt = S_WAIT;
      S_WAIT: begin
        w_nxt = 1'b1;
        if (w_r) begin
          cmd.load_mid = 1'b1; rnd_nxt = '0;
          st_nxt = sts.flat ? S_OUT : S_SUM;
          w_nxt = 1'b0;
          if (!sts.flat) w_nxt = 1'b1;
        end
      end
      S_SUM: begin
        if (w_r) cmd.acc_start = 1'b1;
        if (sts.sweep_done) begin
          cmd.div_start = 1'b1; st_nxt = S_DIV;
        end
      end
      S_DIV: if (sts.div_done) st_nxt = S_STEP;
      S_STEP: begin
        rnd_nxt = rnd_r + 1'b1;
        if (sts.converged || rnd_nxt >= lim) st_nxt = S_OUT;
        else begin
          cmd.take_next = 1'b1; st_nxt = S_SUM; w_nxt = 1'b1;
        end
      end
      S_OUT: begin
        done = 1'b1; cmd.frame_clear = 1'b1; cmd.clr_start = 1'b1;
        st_nxt = S_CLR;
      end
      S_CLR: if (sts.sweep_done) st_nxt = S_RUN;
      default: st_nxt = S_INIT;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_INIT; rnd_r <= '0; w_r <= 1'b0;
    end else begin
      st_r <= st_nxt; rnd_r <= rnd_nxt; w_r <= w_nxt;
    end
  end

  assign busy = (st_r != S_RUN);

  assert property (@(posedge clk) disable iff (!rst_n) done |=> busy)
    else $error("idle right after result");
  assert property (@(posedge clk) disable iff (!rst_n) cmd.div_start |-> st_r == S_SUM)
    else $error("divide outside sum");
  assert property (@(posedge clk) disable iff (!rst_n) st_r == S_STEP |-> rnd_r < lim)
    else $error("round limit passed");
endmodule
`default_nettype wire

[hdl/iterative_isodata_threshold.sv]
// channel | ports                                  | beat
// in      | start, busy, in_pixel, in_last_pixel   | start & !busy
// out     | out_valid, out_threshold               | out_valid, one cycle
// cfg     | cfg_valid, cfg_ready, cfg_max_iterations | cfg_valid & cfg_ready
// pixels: one per cycle while busy is low and the frame arrives (histogram memory read-modify-write)
// end of frame: rounds of sum sweep, divide and step run until the result (none for a flat frame)
// after each result the histogram clear holds busy, and it does so after reset as well
// reset clears control, min/max and sets the round limit to 100
// the receiver cannot stall results
`default_nettype none
module iterative_isodata_threshold (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       start,
  output logic            busy,
  input  wire logic [7:0] in_pixel,
  input  wire logic       in_last_pixel,
  output logic            out_valid,
  output logic [7:0]      out_threshold,
  input  wire logic       cfg_valid,
  output logic            cfg_ready,
  input  wire logic [7:0] cfg_max_iterations
);
  import iit_pkg::*;

  ctl_cmd_t   cmd;
  ctl_sts_t   sts;
  logic [7:0] iter_r;
  logic       acc;

  assign acc = start && !busy;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) iter_r <= ITER_RESET;
    else if (cfg_valid && cfg_ready) iter_r <= cfg_max_iterations;
  end

  iit_ctrl u_ctrl (
    .clk, .rst_n, .start(acc), .in_last_pixel, .max_iter(iter_r),
    .sts, .cmd, .busy, .done(out_valid)
  );

  iit_datapath u_dp (
    .clk, .rst_n, .px_we(acc), .px(in_pixel), .cmd, .sts, .thr(out_threshold)
  );
endmodule
`default_nettype wire
